>>> design/average_true_range_bars_defines.svh
// Assertion macros for the average true range bar block.
// Used by the top level only; needs a clock i_clk and a reset i_rst_n in scope.
`ifndef AVERAGE_TRUE_RANGE_BARS_DEFINES_SVH
`define AVERAGE_TRUE_RANGE_BARS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ATRB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ATRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/atrb_pkg.sv
// Shared types and constants for the average true range bar block.
// No dependencies; imported by the top level, controller, datapath and divider.
package atrb_pkg;

    localparam int PRICE_W = 32;
    localparam int P_W     = 5;
    localparam int ACC_W   = PRICE_W + P_W;

    localparam logic CFG_PERIOD      = 1'b0;
    localparam logic CFG_BAR_SECONDS = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_OPEN,
        OP_RD_NEW,
        OP_UPD,
        OP_RD_PRV,
        OP_TR,
        OP_MUL,
        OP_WK_START,
        OP_WK_FIRST,
        OP_WK_STEP,
        OP_DIV_START,
        OP_DIV_END,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic first;
        logic in_bar;
        logic enough;
        logic prev_nz;
        logic walk_last;
        logic div_done;
        logic div_busy;
    } t_sts;

endpackage

>>> design/average_true_range_bars.sv
// Top level of the average true range bar block.
// Depends on atrb_pkg, atrb_ctrl, atrb_dp and the assertion macro header.
//
// Ticks (price, timestamp) arrive one beat at a time and are grouped into bars of
// bar_seconds seconds; up to MAX_PERIOD+1 bars are held in a ring memory of high, low
// and close. Every tick returns one beat carrying the current ATR, a flag that at
// least period bars are held, and a flag that the tick opened a new bar. The ATR is
// the simple mean of the window's ranges while no previous ATR exists, and Wilder
// smoothing afterwards. One tick is processed at a time. A tick that yields a new ATR
// waits on the restoring divider of the 37-bit accumulator; a seed mean also waits on
// the single read port of the bar memory, which the seed walk visits one bar per cycle.
// The result sits in an output register, so the next tick is taken while an earlier
// beat still waits. Configuration (period at index 0, bar_seconds at index 1) is
// to be written by the user only when idle; the block does not enforce this.
// The bar memory needs no clearing after reset: only bars that are held are read.
`include "average_true_range_bars_defines.svh"

module average_true_range_bars #(
    parameter int MAX_PERIOD = 31
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [31:0]                  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [atrb_pkg::PRICE_W-1:0] i_price,
    input  logic [31:0]                  i_time_sec,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [atrb_pkg::PRICE_W-1:0] o_atr,
    output logic                         o_atr_ready,
    output logic                         o_new_bar
);
    import atrb_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // The controller only sequences; all state of the bars lives in the datapath.
    atrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    atrb_dp #(
        .MAX_PERIOD (MAX_PERIOD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_price     (i_price),
        .i_time_sec  (i_time_sec),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_atr       (o_atr),
        .o_atr_ready (o_atr_ready),
        .o_new_bar   (o_new_bar)
    );

    // Once a tick is taken, no other tick is taken until its result is formed.
    `ATRB_ASSERT_NEXT(a_one_tick, i_in_valid && o_in_ready, !o_in_ready, "second tick taken")
    // The divider only runs in the middle of a tick.
    `ATRB_ASSERT_NOW(a_div_busy, w_sts.div_busy, !o_in_ready, "divider busy while idle")
    // The output is only loaded when the previous result has gone or is leaving.
    `ATRB_ASSERT_NOW(a_out_load, w_cmd.op == OP_OUT, !o_out_valid || i_out_ready, "result lost")

endmodule

>>> design/atrb_div.sv
// Restoring divider: one quotient bit per cycle over the ACC_W-bit dividend.
// Depends on atrb_pkg for widths.
module atrb_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [atrb_pkg::ACC_W-1:0] i_dividend,
    input  logic [atrb_pkg::P_W-1:0]   i_divisor,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [atrb_pkg::ACC_W-1:0] o_quot
);
    import atrb_pkg::*;

    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0] r_q;
    logic [P_W-1:0]   r_rem;
    logic [P_W-1:0]   r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [P_W:0]     w_trial;
    logic [P_W-1:0]   n_rem;
    logic             n_bit;

    always_comb begin
        w_trial = {r_rem, r_q[ACC_W-1]};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = P_W'(w_trial - {1'b0, r_div});
            n_bit = 1'b1;
        end else begin
            n_rem = w_trial[P_W-1:0];
            n_bit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_q   <= {r_q[ACC_W-2:0], n_bit};
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ACC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> design/atrb_dp.sv
// Datapath: configuration, bar ring memory, true range, accumulator, divider.
// Depends on atrb_pkg and atrb_div; driven by commands from atrb_ctrl.
module atrb_dp #(
    parameter int MAX_PERIOD = 31
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [31:0]                  i_cfg_data,
    input  logic [atrb_pkg::PRICE_W-1:0] i_price,
    input  logic [31:0]                  i_time_sec,
    input  atrb_pkg::t_cmd               i_cmd,
    output atrb_pkg::t_sts               o_sts,
    output logic [atrb_pkg::PRICE_W-1:0] o_atr,
    output logic                         o_atr_ready,
    output logic                         o_new_bar
);
    import atrb_pkg::*;

    localparam int SLOTS = MAX_PERIOD + 1;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int CMP_W = (CNT_W > P_W) ? CNT_W : P_W;
    localparam logic [CNT_W:0] SLOTS_X = (CNT_W + 1)'(SLOTS);
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

    function automatic logic [IDX_W-1:0] f_slot(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] k);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(base) + (CNT_W + 1)'(k);
        if (s >= SLOTS_X) begin
            s = s - SLOTS_X;
        end
        return IDX_W'(s);
    endfunction

    function automatic logic [PRICE_W-1:0] f_tr(input logic [PRICE_W-1:0] hi,
                                                 input logic [PRICE_W-1:0] lo,
                                                 input logic [PRICE_W-1:0] pc);
        logic [PRICE_W-1:0] r;
        logic [PRICE_W-1:0] d;
        r = hi - lo;
        d = (hi > pc) ? hi - pc : pc - hi;
        if (d > r) begin
            r = d;
        end
        d = (lo > pc) ? lo - pc : pc - lo;
        if (d > r) begin
            r = d;
        end
        return r;
    endfunction

    logic [3*PRICE_W-1:0] mem [SLOTS];

    logic [P_W-1:0]       r_period;
    logic [31:0]          r_bar_seconds;
    logic [PRICE_W-1:0]   r_price;
    logic [31:0]          r_time;
    logic                 r_opened;
    logic [31:0]          r_last_start;
    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_oldest;
    logic [PRICE_W-1:0]   r_cur;
    logic [PRICE_W-1:0]   r_prev;
    logic [3*PRICE_W-1:0] r_rdata;
    logic [3*PRICE_W-1:0] r_nw;
    logic [PRICE_W-1:0]   r_tr;
    logic [PRICE_W-1:0]   r_pclose;
    logic [ACC_W-1:0]     r_acc;
    logic [CNT_W-1:0]     r_k;
    logic [PRICE_W-1:0]   r_o_atr;
    logic                 r_o_ready;
    logic                 r_o_new;

    logic [CMP_W-1:0]     w_p_ext;
    logic [P_W-1:0]       w_p;
    logic [CNT_W-1:0]     w_p_cnt;
    logic                 w_enough;
    logic [31:0]          w_limit;
    logic [IDX_W-1:0]     w_raddr;
    logic                 w_re;
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    logic [3*PRICE_W-1:0] w_wdata;
    logic                 w_full;
    logic [PRICE_W-1:0]   w_rd_hi;
    logic [PRICE_W-1:0]   w_rd_lo;
    logic [PRICE_W-1:0]   w_rd_cl;
    logic [PRICE_W-1:0]   w_up_hi;
    logic [PRICE_W-1:0]   w_up_lo;
    logic [ACC_W-1:0]     w_prod;
    logic                 w_div_start;
    logic                 w_div_busy;
    logic                 w_div_done;
    logic [ACC_W-1:0]     w_quot;

    // Period is clamped to the range the ring supports.
    always_comb begin
        w_p_ext = CMP_W'(r_period);
        if (w_p_ext < CMP_W'(2)) begin
            w_p_ext = CMP_W'(2);
        end else if (w_p_ext > CMP_W'(MAX_PERIOD)) begin
            w_p_ext = CMP_W'(MAX_PERIOD);
        end
    end
    assign w_p      = P_W'(w_p_ext);
    assign w_p_cnt  = CNT_W'(w_p_ext);
    assign w_enough = CMP_W'(r_count) >= w_p_ext;
    assign w_limit  = r_last_start + r_bar_seconds;
    assign w_full   = (r_count == SLOTS_C);

    assign w_rd_hi = r_rdata[3*PRICE_W-1:2*PRICE_W];
    assign w_rd_lo = r_rdata[2*PRICE_W-1:PRICE_W];
    assign w_rd_cl = r_rdata[PRICE_W-1:0];

    always_comb begin
        w_up_lo = w_rd_lo;
        w_up_hi = w_rd_hi;
        if (w_rd_lo > r_price) begin
            w_up_lo = r_price;
        end else if (w_rd_hi < r_price) begin
            w_up_hi = r_price;
        end
    end

    assign w_prod = ACC_W'(r_prev) * ACC_W'(w_p - 1'b1) + ACC_W'(r_tr);

    always_comb begin
        w_re    = 1'b0;
        w_raddr = f_slot(r_oldest, r_k);
        w_we    = 1'b0;
        w_waddr = f_slot(r_oldest, r_count);
        w_wdata = {r_price, r_price, r_price};
        unique case (i_cmd.op)
            OP_RD_NEW: begin
                w_re    = 1'b1;
                w_raddr = f_slot(r_oldest, r_count - 1'b1);
            end
            OP_RD_PRV: begin
                w_re    = 1'b1;
                w_raddr = f_slot(r_oldest, r_count - 2'd2);
            end
            OP_WK_START: begin
                w_re    = 1'b1;
                w_raddr = r_oldest;
            end
            OP_WK_FIRST, OP_WK_STEP: begin
                w_re = 1'b1;
            end
            OP_OPEN: begin
                w_we = 1'b1;
                // A full ring reuses the oldest entry.
                if (w_full) begin
                    w_waddr = r_oldest;
                end
            end
            OP_UPD: begin
                w_we    = 1'b1;
                w_waddr = f_slot(r_oldest, r_count - 1'b1);
                w_wdata = {w_up_hi, w_up_lo, r_price};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    assign w_div_start = (i_cmd.op == OP_DIV_START);

    atrb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_acc),
        .i_divisor  (w_p),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period      <= P_W'(14);
            r_bar_seconds <= 32'd60;
            r_last_start  <= '0;
            r_count       <= '0;
            r_oldest      <= '0;
            r_cur         <= '0;
            r_prev        <= '0;
            r_k           <= '0;
            r_opened      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PERIOD:      r_period      <= i_cfg_data[P_W-1:0];
                    CFG_BAR_SECONDS: r_bar_seconds <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_price  <= i_price;
                    r_time   <= i_time_sec;
                    r_opened <= 1'b0;
                end
                OP_OPEN: begin
                    r_opened     <= 1'b1;
                    r_last_start <= r_time;
                    if (w_full) begin
                        r_oldest <= f_slot(r_oldest, CNT_W'(1));
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                end
                OP_RD_PRV: begin
                    r_nw <= r_rdata;
                end
                OP_TR: begin
                    r_tr <= f_tr(r_nw[3*PRICE_W-1:2*PRICE_W],
                                 r_nw[2*PRICE_W-1:PRICE_W], w_rd_cl);
                    // Drop the oldest bars down to the period; smoothing
                    // then starts from the ATR held before this tick.
                    if (CMP_W'(r_count) > w_p_ext) begin
                        r_oldest <= f_slot(r_oldest, r_count - w_p_cnt);
                        r_count  <= w_p_cnt;
                        r_prev   <= r_cur;
                    end
                end
                OP_MUL: begin
                    r_acc <= w_prod;
                end
                OP_WK_START: begin
                    r_k <= CNT_W'(1);
                end
                OP_WK_FIRST: begin
                    r_acc    <= ACC_W'(w_rd_hi - w_rd_lo);
                    r_pclose <= w_rd_cl;
                    r_k      <= r_k + 1'b1;
                end
                OP_WK_STEP: begin
                    r_acc    <= r_acc + ACC_W'(f_tr(w_rd_hi, w_rd_lo, r_pclose));
                    r_pclose <= w_rd_cl;
                    r_k      <= r_k + 1'b1;
                end
                OP_DIV_END: begin
                    r_cur <= w_quot[PRICE_W-1:0];
                end
                OP_OUT: begin
                    r_o_atr   <= r_cur;
                    r_o_ready <= w_enough;
                    r_o_new   <= r_opened;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_sts.first     = (r_count == '0);
    assign o_sts.in_bar    = (r_time < w_limit);
    assign o_sts.enough    = w_enough;
    assign o_sts.prev_nz   = (r_prev != '0);
    assign o_sts.walk_last = (r_k == r_count);
    assign o_sts.div_done  = w_div_done;
    assign o_sts.div_busy  = w_div_busy;

    assign o_atr       = r_o_atr;
    assign o_atr_ready = r_o_ready;
    assign o_new_bar   = r_o_new;

endmodule

>>> design/atrb_ctrl.sv
// Controller state machine: sequences one tick through the datapath.
// Depends on atrb_pkg for the command and status types.
module atrb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  atrb_pkg::t_sts i_sts,
    output atrb_pkg::t_cmd o_cmd
);
    import atrb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASS,
        S_UPD,
        S_RC,
        S_RC_PRV,
        S_TR,
        S_SEL,
        S_WK1,
        S_WK,
        S_DIVGO,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CLASS;
                end
            end
            S_CLASS: begin
                if (i_sts.first) begin
                    o_cmd.op = OP_OPEN;
                    n_state  = S_OUT;
                end else if (i_sts.in_bar) begin
                    o_cmd.op = OP_RD_NEW;
                    n_state  = S_UPD;
                end else begin
                    o_cmd.op = OP_OPEN;
                    n_state  = S_RC;
                end
            end
            S_UPD: begin
                o_cmd.op = OP_UPD;
                n_state  = S_RC;
            end
            S_RC: begin
                if (i_sts.enough) begin
                    o_cmd.op = OP_RD_NEW;
                    n_state  = S_RC_PRV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RC_PRV: begin
                o_cmd.op = OP_RD_PRV;
                n_state  = S_TR;
            end
            S_TR: begin
                o_cmd.op = OP_TR;
                n_state  = S_SEL;
            end
            S_SEL: begin
                if (i_sts.prev_nz) begin
                    o_cmd.op = OP_MUL;
                    n_state  = S_DIVGO;
                end else begin
                    o_cmd.op = OP_WK_START;
                    n_state  = S_WK1;
                end
            end
            S_WK1: begin
                o_cmd.op = OP_WK_FIRST;
                n_state  = S_WK;
            end
            S_WK: begin
                // The bar read on the previous cycle is added here; the newest bar ends the walk.
                o_cmd.op = OP_WK_STEP;
                if (i_sts.walk_last) begin
                    n_state = S_DIVGO;
                end
            end
            S_DIVGO: begin
                o_cmd.op = OP_DIV_START;
                n_state  = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.op = OP_DIV_END;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
